>>> hdl/wsp_pkg.sv
`timescale 1ns / 1ps

package wsp_pkg;

    // Width of the tested bound and of the counters derived from it.
    localparam int LIMIT_W  = 16;
    localparam int INDEX_W  = LIMIT_W + 1;   // bound plus one stride
    localparam int ROOT_W   = 10;            // base or wheel candidate
    localparam int SQUARE_W = 2 * ROOT_W;
    localparam int BASE_W   = 8;
    localparam int RES_W    = 8;
    localparam int RIDX_W   = 6;

    localparam int WHEEL_SPAN  = 210;
    localparam int WHEEL_COUNT = 48;
    localparam int BASE_FIRST  = 2;
    localparam int BASE_LAST   = WHEEL_SPAN;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_CLEAR = 11'b00000000010,
        ST_BSQ   = 11'b00000000100,
        ST_BTEST = 11'b00000001000,
        ST_MARK  = 11'b00000010000,
        ST_WOUT  = 11'b00000100000,
        ST_WOCHK = 11'b00001000000,
        ST_WSQ   = 11'b00010000000,
        ST_WTEST = 11'b00100000000,
        ST_FINAL = 11'b01000000000,
        ST_FRES  = 11'b10000000000
    } wsp_state_t;

    // Residues below 210 that are coprime to 210.
    function automatic logic [RES_W-1:0] wheel_residue(input logic [RIDX_W-1:0] idx);
        logic [RES_W-1:0] r;
        case (idx)
            6'd0:  r = 8'd1;   6'd1:  r = 8'd11;  6'd2:  r = 8'd13;  6'd3:  r = 8'd17;
            6'd4:  r = 8'd19;  6'd5:  r = 8'd23;  6'd6:  r = 8'd29;  6'd7:  r = 8'd31;
            6'd8:  r = 8'd37;  6'd9:  r = 8'd41;  6'd10: r = 8'd43;  6'd11: r = 8'd47;
            6'd12: r = 8'd53;  6'd13: r = 8'd59;  6'd14: r = 8'd61;  6'd15: r = 8'd67;
            6'd16: r = 8'd71;  6'd17: r = 8'd73;  6'd18: r = 8'd79;  6'd19: r = 8'd83;
            6'd20: r = 8'd89;  6'd21: r = 8'd97;  6'd22: r = 8'd101; 6'd23: r = 8'd103;
            6'd24: r = 8'd107; 6'd25: r = 8'd109; 6'd26: r = 8'd113; 6'd27: r = 8'd121;
            6'd28: r = 8'd127; 6'd29: r = 8'd131; 6'd30: r = 8'd137; 6'd31: r = 8'd139;
            6'd32: r = 8'd143; 6'd33: r = 8'd149; 6'd34: r = 8'd151; 6'd35: r = 8'd157;
            6'd36: r = 8'd163; 6'd37: r = 8'd167; 6'd38: r = 8'd169; 6'd39: r = 8'd173;
            6'd40: r = 8'd179; 6'd41: r = 8'd181; 6'd42: r = 8'd187; 6'd43: r = 8'd191;
            6'd44: r = 8'd193; 6'd45: r = 8'd197; 6'd46: r = 8'd199; 6'd47: r = 8'd209;
            default: r = 8'd1;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/wsp_ram.sv
`timescale 1ns / 1ps

module wsp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/wheel_sieve_prime_test.sv
`timescale 1ns / 1ps

// Primality test of one 16-bit number by a sieve of Eratosthenes with a 210 wheel.
// A request on the slave stream carries the number in s_tdata[15:0]; it is taken
// when s_tvalid and s_tready are both high. A number above MAX_VALUE - 1 is
// saturated to MAX_VALUE - 1 before it is tested.
// One result leaves on the master stream per request: m_tdata[0] is 1 if the
// number is prime. Numbers 0 and 1 are reported as not prime.
// The block works on one request at a time and holds s_tready low until the
// sieve is done. It clears the bit store up to the bound B, tests each base
// from 2 up to sqrt(B) (at most 210), tests each wheel candidate, marks the
// multiples of each sieving prime, and ends with a lookup of the bound. The
// bit store (one write and one read a cycle) and the one adder that walks the
// multiples set the pace of the sieve.
// The result sits in an output register; a new request is accepted while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds in its last step until the previous result is taken.
// Reset clears the control state; the bit store needs no clearing pass
// because every request clears the entries it uses before reading them.
module wheel_sieve_prime_test #(
    parameter int MAX_VALUE = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // [15:0] limit_value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [0] is_prime, [7:1] zero
);

    import wsp_pkg::*;

    localparam int AW = $clog2(MAX_VALUE);
    localparam logic [LIMIT_W-1:0] BOUND_MAX =
        (MAX_VALUE > 65536) ? {LIMIT_W{1'b1}} : LIMIT_W'(MAX_VALUE - 1);

    wsp_state_t            state_reg, state_next;
    logic [LIMIT_W-1:0]    bound_reg, bound_next;
    logic [INDEX_W-1:0]    k_reg, k_next;
    logic [ROOT_W:0]       step_reg, step_next;
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [ROOT_W-1:0]     wb_reg, wb_next;
    logic [RIDX_W-1:0]     ridx_reg, ridx_next;
    logic [ROOT_W-1:0]     cand_reg, cand_next;
    logic [SQUARE_W-1:0]   sq_reg, sq_next;
    logic                  ret_wheel_reg, ret_wheel_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  is_prime_reg, is_prime_next;

    logic [ROOT_W-1:0]     mul_a;
    logic [SQUARE_W-1:0]   sq_prod;
    logic [ROOT_W-1:0]     cand_val;
    logic [INDEX_W-1:0]    add_b;
    logic [INDEX_W-1:0]    add_sum;
    logic                  sq_over;
    logic                  k_over;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic                  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic                  ram_rdata;

    wsp_ram #(
        .WIDTH (1),
        .DEPTH (MAX_VALUE)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The shared adder: it steps the clear index by one and the marking
    // index by the stride of the current prime.
    assign add_b   = (state_reg == ST_CLEAR) ? INDEX_W'(1) : INDEX_W'(step_reg);
    assign add_sum = k_reg + add_b;

    assign cand_val = wb_reg + ROOT_W'(wheel_residue(ridx_reg));
    assign sq_over  = sq_reg > SQUARE_W'(bound_reg);
    assign k_over   = k_reg > INDEX_W'(bound_reg);

    always_comb
    begin
        case (state_reg)
            ST_BSQ:  mul_a = ROOT_W'(base_reg);
            ST_WOUT: mul_a = wb_reg + ROOT_W'(1);
            default: mul_a = cand_val;
        endcase
    end

    assign sq_prod = SQUARE_W'(mul_a) * SQUARE_W'(mul_a);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_waddr = AW'(k_reg);
        case (state_reg)
            ST_BSQ:  ram_raddr = AW'(base_reg);
            ST_WSQ:  ram_raddr = AW'(cand_val);
            default: ram_raddr = AW'(bound_reg);
        endcase
        if (state_reg == ST_CLEAR)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_MARK && !k_over)
        begin
            ram_we    = 1'b1;
            ram_wdata = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bound_next     = bound_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        base_next      = base_reg;
        wb_next        = wb_reg;
        ridx_next      = ridx_reg;
        cand_next      = cand_reg;
        sq_next        = sq_reg;
        ret_wheel_next = ret_wheel_reg;
        is_prime_next  = is_prime_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    bound_next = (s_tdata > BOUND_MAX) ? BOUND_MAX : s_tdata;
                    k_next     = '0;
                    base_next  = BASE_W'(BASE_FIRST);
                    wb_next    = ROOT_W'(WHEEL_SPAN);
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                k_next = add_sum;
                if (k_reg == INDEX_W'(bound_reg))
                begin
                    state_next = ST_BSQ;
                end
            end
            ST_BSQ:
            begin
                sq_next    = sq_prod;
                state_next = ST_BTEST;
            end
            ST_BTEST:
            begin
                if (sq_over)
                begin
                    state_next = ST_WOUT;
                end
                else if (!ram_rdata)
                begin
                    k_next         = INDEX_W'(sq_reg);
                    step_next      = (ROOT_W + 1)'(base_reg);
                    ret_wheel_next = 1'b0;
                    state_next     = ST_MARK;
                end
                else if (base_reg == BASE_W'(BASE_LAST))
                begin
                    state_next = ST_WOUT;
                end
                else
                begin
                    base_next  = base_reg + BASE_W'(1);
                    state_next = ST_BSQ;
                end
            end
            ST_MARK:
            begin
                if (!k_over)
                begin
                    k_next = add_sum;
                end
                else if (ret_wheel_reg)
                begin
                    if (ridx_reg == RIDX_W'(WHEEL_COUNT - 1))
                    begin
                        wb_next    = wb_reg + ROOT_W'(WHEEL_SPAN);
                        state_next = ST_WOUT;
                    end
                    else
                    begin
                        ridx_next  = ridx_reg + RIDX_W'(1);
                        state_next = ST_WSQ;
                    end
                end
                else if (base_reg == BASE_W'(BASE_LAST))
                begin
                    state_next = ST_WOUT;
                end
                else
                begin
                    base_next  = base_reg + BASE_W'(1);
                    state_next = ST_BSQ;
                end
            end
            ST_WOUT:
            begin
                sq_next    = sq_prod;
                state_next = ST_WOCHK;
            end
            ST_WOCHK:
            begin
                ridx_next  = '0;
                state_next = sq_over ? ST_FINAL : ST_WSQ;
            end
            ST_WSQ:
            begin
                sq_next    = sq_prod;
                cand_next  = cand_val;
                state_next = ST_WTEST;
            end
            ST_WTEST:
            begin
                if (!sq_over && !ram_rdata)
                begin
                    k_next         = INDEX_W'(sq_reg);
                    step_next      = {cand_reg, 1'b0};
                    ret_wheel_next = 1'b1;
                    state_next     = ST_MARK;
                end
                else if (ridx_reg == RIDX_W'(WHEEL_COUNT - 1))
                begin
                    wb_next    = wb_reg + ROOT_W'(WHEEL_SPAN);
                    state_next = ST_WOUT;
                end
                else
                begin
                    ridx_next  = ridx_reg + RIDX_W'(1);
                    state_next = ST_WSQ;
                end
            end
            ST_FINAL:
            begin
                state_next = ST_FRES;
            end
            ST_FRES:
            begin
                // The read address stays on the bound, so the lookup holds
                // while an earlier result waits.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    is_prime_next  = (bound_reg >= LIMIT_W'(2)) && !ram_rdata;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ret_wheel_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            ret_wheel_reg <= ret_wheel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bound_reg    <= bound_next;
        k_reg        <= k_next;
        step_reg     <= step_next;
        base_reg     <= base_next;
        wb_reg       <= wb_next;
        ridx_reg     <= ridx_next;
        cand_reg     <= cand_next;
        sq_reg       <= sq_next;
        is_prime_reg <= is_prime_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, is_prime_reg};

endmodule

>>> bench/wheel_sieve_prime_test_tb.sv
`timescale 1ns / 1ps

module wheel_sieve_prime_test_tb;

    import wsp_pkg::*;

    // The store is sized for every 16-bit bound, so no bound is ever saturated.
    localparam int MAX_VALUE = 65536;

    // Each random request picks a small bound most of the time. Larger bounds are rare,
    // because the block clears and sieves the whole range for every request.
    localparam int WIDE_PCT   = 3;
    localparam int WIDE_MAX   = 8191;
    localparam int NARROW_MAX = 1023;

    // Cycles to let pass after the last result before the verdict.
    localparam int DRAIN_CYCLES = 50;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [15:0] s_tdata;   // [15:0] limit_value
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [0] is_prime, [7:1] zero

    // Percentages that set how often the sender idles between requests and how
    // often the receiver holds m_tready low. Each test task sets them.
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    // One expected verdict per accepted request, oldest first.
    bit          expected_prime_q[$];
    int unsigned error_count;

    // Sieve state of the predictor: 1 marks a known composite.
    bit          composite_bits [0:MAX_VALUE-1];

    // The residues below 210 that share no factor with 210.
    int unsigned wheel_residues [WHEEL_COUNT] = '{
        1, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67,
        71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 121, 127, 131, 137, 139,
        143, 149, 151, 157, 163, 167, 169, 173, 179, 181, 187, 191, 193, 197, 199, 209
    };

    wheel_sieve_prime_test #(
        .MAX_VALUE (MAX_VALUE)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The predictor runs the same sieve the block runs. It clears the store up to
    // the bound, lets every unmarked base from 2 to 210 strike its multiples from
    // its square on, then walks the 210 wheel. A wheel candidate whose square lies
    // past the bound is skipped without looking at its entry. An unmarked
    // candidate strikes only its odd multiples, since the even ones are already
    // marked by base 2.
    function automatic bit sieve_is_prime(input logic [LIMIT_W-1:0] limit);
        int unsigned bound;
        int unsigned base;
        int unsigned turn;
        int unsigned cand;
        int unsigned k;
        bound = 32'(limit);
        if (bound > MAX_VALUE - 1)
        begin
            bound = MAX_VALUE - 1;
        end
        for (k = 0; k <= bound; k++)
        begin
            composite_bits[k] = 1'b0;
        end
        for (base = BASE_FIRST; base <= BASE_LAST && base * base <= bound; base++)
        begin
            if (!composite_bits[base])
            begin
                for (k = base * base; k <= bound; k += base)
                begin
                    composite_bits[k] = 1'b1;
                end
            end
        end
        for (turn = 1; (WHEEL_SPAN * turn + 1) * (WHEEL_SPAN * turn + 1) <= bound; turn++)
        begin
            foreach (wheel_residues[r])
            begin
                cand = WHEEL_SPAN * turn + wheel_residues[r];
                if (cand * cand <= bound && !composite_bits[cand])
                begin
                    for (k = cand * cand; k <= bound; k += 2 * cand)
                    begin
                        composite_bits[k] = 1'b1;
                    end
                end
            end
        end
        // Zero and one are never prime.
        return (bound >= 2) && !composite_bits[bound];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    // Offers one request and holds it until the block takes it. The expected
    // verdict is queued at the edge of the handshake. Afterwards the sender may
    // idle for a while, with noise on the data lines, before the next request.
    task automatic send_request(input logic [15:0] limit);
        s_tvalid <= 1'b1;
        s_tdata  <= limit;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        expected_prime_q.push_back(sieve_is_prime(limit));
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            @(posedge clk);
        end
    endtask

    // The receiver stalls at random and checks every result it takes against the
    // oldest expectation. Inputs and outputs are sampled as they stood just
    // before the edge, so the handshake seen here is the one the block saw.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_prime_q.size() == 0)
                begin
                    report_mismatch($sformatf("result 0x%02h with no request pending", m_tdata));
                end
                else if (m_tdata !== {7'd0, expected_prime_q[0]})
                begin
                    report_mismatch($sformatf("is_prime got 0x%02h, expected %0d",
                                              m_tdata, expected_prime_q[0]));
                    void'(expected_prime_q.pop_front());
                end
                else
                begin
                    void'(expected_prime_q.pop_front());
                end
            end
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Zero and one must come back as not prime; two, three and four are the
    // first bounds where the base loop and the lookup take part.
    task automatic test_tiny_bounds();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_request(16'd0);
        send_request(16'd1);
        send_request(16'd2);
        send_request(16'd3);
        send_request(16'd4);
    endtask

    // Squares and products of small bases, and bounds around the wheel span.
    // A bound that equals a base square is the first entry that base strikes.
    task automatic test_base_squares();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_request(16'd9);
        send_request(16'd25);
        send_request(16'd49);
        send_request(16'd121);
        send_request(16'd143);
        send_request(16'd169);
        send_request(16'd209);
        send_request(16'd210);
        send_request(16'd211);
        send_request(16'd221);
        send_request(16'd223);
    endtask

    // Only bounds from 211 squared on reach the wheel stage. 211 squared and
    // 251 squared are composites that no base up to 210 strikes, so only the
    // wheel can mark them. The largest 16-bit prime sets the high bits and
    // makes the walk skip the candidates whose square exceeds the bound.
    task automatic test_wheel_candidates();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_request(16'd44521);
        send_request(16'd63001);
        send_request(16'd65521);
    endtask

    // Random bounds under the given idling mix. A share of very small bounds
    // keeps the zero and one cases coming.
    task automatic test_random_bounds(input int count, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
        int          i;
        int unsigned pick;
        logic [15:0] limit;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < WIDE_PCT)
            begin
                limit = 16'($urandom_range(WIDE_MAX));
            end
            else if (pick < 15)
            begin
                limit = 16'($urandom_range(15));
            end
            else
            begin
                limit = 16'($urandom_range(NARROW_MAX));
            end
            send_request(limit);
        end
    endtask

    // Reset is held first, then the tests run in turn. The random part
    // goes through four idling mixes: none, sender only, receiver only, both.
    initial
    begin
        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tiny_bounds();
        test_base_squares();
        test_wheel_candidates();
        test_random_bounds(25, 0, 0);
        test_random_bounds(25, 79, 0);
        test_random_bounds(25, 0, 79);
        test_random_bounds(25, 17, 17);

        s_tvalid <= 1'b0;
        while (expected_prime_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("wheel_sieve_prime_test_tb OK");
        end
        else
        begin
            $display("wheel_sieve_prime_test_tb NOT OK");
        end
        $finish;
    end

    // This guard stops a run that hangs and reports it as NOT OK; it lies past the
    // slowest correct run, even if every random bound came out wide.
    initial
    begin
        #200_000_000;
        $display("wheel_sieve_prime_test_tb NOT OK");
        $finish;
    end

endmodule
